### rtl/pbba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbba_pkg: shared types and constants of the paged bitmap block allocator
// Pool geometry, field widths, status codes, the command word passed from
// the front end to the back end, and the state types of both controllers.
// ----------------------------------------------------------------------------
package pbba_pkg;

  // Pool geometry
  localparam int SLOTS_PER_PAGE = 256;
  localparam int MAX_BLOCKS     = 4096;
  localparam int WORD_BITS      = 32;
  localparam int BITMAP_WORDS   = MAX_BLOCKS / WORD_BITS;
  localparam int WORDS_PER_PAGE = SLOTS_PER_PAGE / WORD_BITS;
  localparam int MAX_PAGES      = MAX_BLOCKS / SLOTS_PER_PAGE;

  // Field and register widths
  localparam int COUNT_W    = 13;
  localparam int SIZE_W     = 16;
  localparam int OFFSET_W   = 28;
  localparam int PAGE_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = $clog2(MAX_BLOCKS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int PAGES_W    = $clog2(MAX_PAGES + 1);
  localparam int PGIDX_W    = $clog2(MAX_PAGES);
  localparam int PAGE_SHIFT = $clog2(SLOTS_PER_PAGE);
  localparam int WADDR_W    = $clog2(BITMAP_WORDS);
  localparam int WLEFT_W    = $clog2(BITMAP_WORDS + 1);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WIP_W      = $clog2(WORDS_PER_PAGE);
  localparam int DCNT_W     = $clog2(OFFSET_W + 1);

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd1;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd64;

  typedef struct packed {
    logic                is_free;
    logic                no_pages;
    logic [PGIDX_W-1:0]  start_pg;
    logic [PAGES_W-1:0]  pages;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  typedef enum logic [0:0] {
    F_IDLE,
    F_WORK
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DIV,
    B_FREE_WR,
    B_MUL,
    B_DONE
  } back_state_t;

  // Block count clipped to the pool size
  function automatic logic [COUNT_W-1:0] live_count(input logic [COUNT_W-1:0] bc);
    logic [COUNT_W-1:0] lim;
    lim = COUNT_W'(MAX_BLOCKS);
    return (bc > lim) ? lim : bc;
  endfunction

  // Pages touched by a live count, rounded up
  function automatic logic [PAGES_W-1:0] page_count(input logic [COUNT_W-1:0] live);
    logic [COUNT_W:0] sum;
    sum = {1'b0, live} + (COUNT_W+1)'(SLOTS_PER_PAGE - 1);
    return PAGES_W'(sum >> PAGE_SHIFT);
  endfunction

endpackage
`default_nettype wire

### rtl/pbba_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbba_if: request and response channels of the block allocator
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface pbba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [pbba_pkg::PAGE_W-1:0]   start_page;
  logic [pbba_pkg::OFFSET_W-1:0] free_offset;

  modport source (output valid, action, start_page, free_offset, input ready);
  modport sink   (input valid, action, start_page, free_offset, output ready);
endinterface

interface pbba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pbba_pkg::STATUS_W-1:0] status;
  logic [pbba_pkg::SLOT_W-1:0]   slot_index;
  logic [pbba_pkg::OFFSET_W-1:0] byte_offset;

  modport source (output valid, status, slot_index, byte_offset, input ready);
  modport sink   (input valid, status, slot_index, byte_offset, output ready);
endinterface
`default_nettype wire

### rtl/pbba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbba_front: request intake and classification
// Latch a request word, count the pages, reduce the start page by repeated
// subtraction of the page count, and hand a command to the queue.
// ----------------------------------------------------------------------------
module pbba_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pbba_pkg::COUNT_W-1:0] block_count,
  pbba_req_if.sink                     req,
  output pbba_pkg::cmd_t               cmd,
  output logic                         cmd_valid,
  input  logic                         cmd_ready
);
  import pbba_pkg::*;

  front_state_t state, state_next;
  cmd_t         cmd_q;
  logic         reduced;

  assign reduced = cmd_q.is_free || cmd_q.no_pages ||
                   ({1'b0, cmd_q.start_pg} < cmd_q.pages);
  assign cmd = cmd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    cmd_valid  = 1'b0;
    case (state)
      F_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = F_WORK;
        end
      end
      F_WORK: begin
        cmd_valid = reduced;
        if (reduced && cmd_ready) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // Payload: load on accept, subtract the page count until below it
  always_ff @(posedge clk) begin
    if (state == F_IDLE && req.valid) begin
      cmd_q.is_free  <= (req.action == ACT_FREE);
      cmd_q.pages    <= page_count(live_count(block_count));
      cmd_q.no_pages <= (page_count(live_count(block_count)) == '0);
      cmd_q.start_pg <= PGIDX_W'(req.start_page);
      cmd_q.offset   <= req.free_offset;
    end else if (state == F_WORK && !reduced) begin
      cmd_q.start_pg <= PGIDX_W'({1'b0, cmd_q.start_pg} - cmd_q.pages);
    end
  end

endmodule
`default_nettype wire

### rtl/pbba_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbba_queue: command queue between front end and back end
// Small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module pbba_queue (
  input  logic           clk,
  input  logic           rst,
  input  pbba_pkg::cmd_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output pbba_pkg::cmd_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import pbba_pkg::*;

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = q_mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### rtl/pbba_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbba_divider: restoring divider, one quotient bit per cycle
// Divide a byte offset by the block size; done pulses when both quotient and
// remainder are valid.
// ----------------------------------------------------------------------------
module pbba_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pbba_pkg::OFFSET_W-1:0] dividend,
  input  logic [pbba_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [pbba_pkg::OFFSET_W-1:0] quotient,
  output logic [pbba_pkg::SIZE_W-1:0]   remainder
);
  import pbba_pkg::*;

  logic                running;
  logic [DCNT_W-1:0]   cnt;
  logic [OFFSET_W-1:0] quo;
  logic [SIZE_W-1:0]   rem;
  logic [SIZE_W:0]     trial;
  logic                fits;

  assign trial     = {rem, quo[OFFSET_W-1]};
  assign fits      = (trial >= {1'b0, divisor});
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == DCNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      cnt <= DCNT_W'(OFFSET_W);
    end else if (running) begin
      quo <= {quo[OFFSET_W-2:0], fits};
      rem <= fits ? SIZE_W'(trial - {1'b0, divisor}) : SIZE_W'(trial);
      cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/pbba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbba_back: bitmap store and command execution
// Hold the used bitmap, scan pages for the lowest free slot, clear slots on
// free, scale slot indexes to byte offsets, and register the response word.
// ----------------------------------------------------------------------------
module pbba_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pbba_pkg::COUNT_W-1:0] block_count,
  input  logic [pbba_pkg::SIZE_W-1:0]  block_size,
  input  pbba_pkg::cmd_t               cmd,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  pbba_rsp_if.source                   rsp
);
  import pbba_pkg::*;

  back_state_t state, state_next;

  // Bitmap store; a word never written reads as all free
  logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] word_vld;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rdata;
  logic                 rd_vld;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] eff_word;

  // Scan control
  cmd_t                 cur;
  logic [PGIDX_W-1:0]   cur_pg;
  logic [WIP_W-1:0]     wi;
  logic [WLEFT_W-1:0]   iss_left;
  logic                 chk_valid;
  logic [WADDR_W-1:0]   chk_addr;
  logic [WADDR_W-1:0]   iss_addr;

  // Hit detection
  logic [COUNT_W-1:0]   live;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] avail;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;

  // Result
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [OFFSET_W-1:0]  res_off;
  logic                 out_load;

  // Divider
  logic                 div_start;
  logic                 div_done;
  logic [OFFSET_W-1:0]  div_quo;
  logic [SIZE_W-1:0]    div_rem;
  logic                 div_oor;

  pbba_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cmd.offset),
    .divisor   (block_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign live     = live_count(block_count);
  assign eff_word = rd_vld ? rdata : '0;
  assign iss_addr = {cur_pg, wi};
  assign div_oor  = (div_quo >= OFFSET_W'(live));

  always_comb begin
    if ((COUNT_W-BIT_W)'(chk_addr) < live[COUNT_W-1:BIT_W]) begin
      lim_mask = '1;
    end else if ((COUNT_W-BIT_W)'(chk_addr) == live[COUNT_W-1:BIT_W]) begin
      lim_mask = ~({WORD_BITS{1'b1}} << live[BIT_W-1:0]);
    end else begin
      lim_mask = '0;
    end
  end

  assign avail = ~eff_word & lim_mask;
  assign hit   = |avail;

  // Lowest free slot in the word under check
  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = iss_addr;
    mem_we     = 1'b0;
    mem_waddr  = chk_addr;
    mem_wdata  = eff_word | (WORD_BITS'(1) << hit_bit);
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.is_free) begin
            if (block_size == '0) begin
              state_next = B_DONE;
            end else begin
              div_start  = 1'b1;
              state_next = B_DIV;
            end
          end else if (cmd.no_pages) begin
            state_next = B_DONE;
          end else begin
            state_next = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (chk_valid && hit) begin
          mem_we     = 1'b1;
          state_next = B_MUL;
        end else if (iss_left != '0) begin
          rd_en = 1'b1;
        end else begin
          state_next = B_DONE;
        end
      end
      B_DIV: begin
        if (div_done) begin
          if (div_oor) begin
            state_next = B_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = div_quo[SLOT_W-1:BIT_W];
            state_next = B_FREE_WR;
          end
        end
      end
      B_FREE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = res_slot[SLOT_W-1:BIT_W];
        mem_wdata  = eff_word & ~(WORD_BITS'(1) << res_slot[BIT_W-1:0]);
        state_next = B_DONE;
      end
      B_MUL: begin
        state_next = B_DONE;
      end
      B_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cur        <= cmd;
          cur_pg     <= cmd.start_pg;
          wi         <= '0;
          iss_left   <= WLEFT_W'(cmd.pages) << WIP_W;
          chk_valid  <= 1'b0;
          res_status <= cmd.is_free ? ST_RANGE : ST_FULL;
          res_slot   <= '0;
          res_off    <= '0;
        end
      end
      B_SCAN: begin
        if (chk_valid && hit) begin
          res_status <= ST_OK;
          res_slot   <= {chk_addr, hit_bit};
          chk_valid  <= 1'b0;
        end else if (iss_left != '0) begin
          chk_valid <= 1'b1;
          chk_addr  <= iss_addr;
          iss_left  <= iss_left - 1'b1;
          if (wi == WIP_W'(WORDS_PER_PAGE - 1)) begin
            wi     <= '0;
            cur_pg <= (({1'b0, cur_pg} + 1'b1) == cur.pages) ? '0 : cur_pg + 1'b1;
          end else begin
            wi <= wi + 1'b1;
          end
        end else begin
          chk_valid <= 1'b0;
        end
      end
      B_DIV: begin
        if (div_done && !div_oor) begin
          res_status <= ST_OK;
          res_slot   <= div_quo[SLOT_W-1:0];
          res_off    <= cur.offset - OFFSET_W'(div_rem);
        end
      end
      B_MUL: begin
        res_off <= OFFSET_W'(res_slot) * OFFSET_W'(block_size);
      end
      default: begin
      end
    endcase
  end

  // Bitmap store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= bitmap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (mem_we) begin
        word_vld[mem_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= word_vld[rd_addr];
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status      <= res_status;
      rsp.slot_index  <= res_slot;
      rsp.byte_offset <= res_off;
    end
  end

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.slot_index == '0 && rsp.byte_offset == '0))
    else $error("failed response carries a slot or offset");

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_OK) |-> ({1'b0, rsp.slot_index} < live))
    else $error("slot at or above block count reported");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN && iss_left == '0 && !chk_valid) |=> (state != B_SCAN))
    else $error("scan did not stop after last word");

endmodule
`default_nettype wire

### rtl/paged_bitmap_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paged_bitmap_block_allocator_unit: fixed-size block allocator
// Allocate the lowest free slot of a page, searching pages in wrapping order,
// or free a slot given its byte offset. One response word per request word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        word contents
//  -------  ---  ---------------  --------------------------------------------
//  req      in   valid/ready      action, start_page, free_offset
//  rsp      out  valid/ready      status, slot_index, byte_offset
//  cfg      in   cfg_we           cfg_index (0 count, 1 size), cfg_wdata
//
//  Allocate reads bitmap words through the single-port bitmap read in the back
//  end (8 per page scanned, at most 128).
//  Free divides its byte offset by the block size, one quotient bit per cycle.
//  The front end reduces the start page by subtraction, overlapped with
//  the back end through a two-entry command queue.
//  Reset clears the bitmap at once through per-word valid bits; no sweep.
//  A waiting response holds the back end; the front end keeps accepting
//  until the queue fills.
//
module paged_bitmap_block_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pbba_req_if.sink                        req,
  pbba_rsp_if.source                      rsp
);
  import pbba_pkg::*;

  // Configuration registers
  logic [COUNT_W-1:0] block_count;
  logic [SIZE_W-1:0]  block_size;

  // Front to queue, queue to back
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // Write configuration; only legal while the unit is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
      block_size  <= BLOCK_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_COUNT: block_count <= cfg_wdata[COUNT_W-1:0];
        REG_BLOCK_SIZE:  block_size  <= cfg_wdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify requests and reduce the start page
  pbba_front u_front (
    .clk         (clk),
    .rst         (rst),
    .block_count (block_count),
    .req         (req),
    .cmd         (front_cmd),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready)
  );

  // Decouple intake from execution
  pbba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Scan, free, scale and respond
  pbba_back u_back (
    .clk         (clk),
    .rst         (rst),
    .block_count (block_count),
    .block_size  (block_size),
    .cmd         (back_cmd),
    .cmd_valid   (back_valid),
    .cmd_ready   (back_ready),
    .rsp         (rsp)
  );

endmodule
`default_nettype wire

### dv/paged_bitmap_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_bitmap_block_allocator_unit_tb: self-checking bench of the allocator
// Drive allocate and free words into the request channel while the response
// channel stalls at random. Keep a private copy of the used bitmap and of the
// two pool registers, predict each response word when its request is taken,
// and compare every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module paged_bitmap_block_allocator_unit_tb;
  import pbba_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_PAD  = 4;
  localparam int END_PAD     = 40;

  // One response word as the allocator should produce it
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
  } pool_reply_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pbba_req_if req_ch ();
  pbba_rsp_if rsp_ch ();

  paged_bitmap_block_allocator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the pool: bitmap plus the two registers as last written
  logic [WORD_BITS-1:0] used_map [BITMAP_WORDS];
  logic [COUNT_W-1:0]   model_count;
  logic [SIZE_W-1:0]    model_size;

  // Predicted response words, oldest first
  pool_reply_t replies_due [$];

  int errors      = 0;
  int cycle_count = 0;
  int idle_pct    = 0;   // chance in percent of an idle burst, per request word and per ready decision
  int hold_order  = 0;   // bump to ask the receiver for one long hold
  int hold_span   = 0;   // length of that hold in cycles
  int hold_served = 0;
  int hold_left   = 0;
  int gap_left    = 0;

  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("paged_bitmap_block_allocator_unit_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Slots actually in play: a count above the pool acts as the pool size
  function automatic int pool_limit();
    return (model_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(model_count);
  endfunction

  // Search pages in wrapping order from the reduced start page and take the
  // lowest free slot of the first page that has one.
  function automatic pool_reply_t grant_slot(input logic [PAGE_W-1:0] pg);
    pool_reply_t     r;
    int              lim;
    int              pages;
    int              first;
    int              page;
    int              lo;
    int              hi;
    longint unsigned prod;
    r     = '{status: ST_FULL, slot: '0, offset: '0};
    lim   = pool_limit();
    pages = (lim + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
    if (pages == 0) return r;
    first = int'(pg) % pages;
    for (int p = 0; p < pages; p++) begin
      page = (first + p) % pages;
      lo   = page * SLOTS_PER_PAGE;
      hi   = lo + SLOTS_PER_PAGE;
      if (hi > lim) hi = lim;
      for (int s = lo; s < hi; s++) begin
        if (!used_map[s / WORD_BITS][s % WORD_BITS]) begin
          used_map[s / WORD_BITS][s % WORD_BITS] = 1'b1;
          prod     = longint'(s) * model_size;
          r.status = ST_OK;
          r.slot   = SLOT_W'(s);
          r.offset = prod[OFFSET_W-1:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  // Truncating divide finds the slot; out of range leaves the bitmap alone
  function automatic pool_reply_t release_slot(input logic [OFFSET_W-1:0] off);
    pool_reply_t     r;
    longint unsigned slot;
    longint unsigned prod;
    r = '{status: ST_RANGE, slot: '0, offset: '0};
    if (model_size == 0) return r;
    slot = longint'(off) / model_size;
    if (slot >= longint'(pool_limit())) return r;
    used_map[slot / WORD_BITS][slot % WORD_BITS] = 1'b0;
    prod     = slot * model_size;
    r.status = ST_OK;
    r.slot   = slot[SLOT_W-1:0];
    r.offset = prod[OFFSET_W-1:0];
    return r;
  endfunction

  // Pick a slot in use, from a random start, or -1 when none is
  function automatic int pick_used_slot();
    int lim;
    int base;
    int s;
    lim = pool_limit();
    if (lim == 0) return -1;
    base = $urandom_range(lim - 1);
    for (int k = 0; k < lim; k++) begin
      s = (base + k) % lim;
      if (used_map[s / WORD_BITS][s % WORD_BITS]) return s;
    end
    return -1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one request word, maybe after an idle burst; predict on acceptance
  task automatic send_word(input logic act, input logic [PAGE_W-1:0] pg,
                           input logic [OFFSET_W-1:0] off);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.start_page  <= pg;
    req_ch.free_offset <= off;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (act == ACT_FREE) replies_due.push_back(release_slot(off));
    else replies_due.push_back(grant_slot(pg));
  endtask

  // Mostly allocations and frees of slots in use (some unaligned), the rest
  // noise: random offsets and offsets right at the top of the pool.
  task automatic send_mixed_word();
    int                  roll;
    int                  slot;
    longint unsigned     byte_pos;
    logic [OFFSET_W-1:0] off;
    roll = $urandom_range(99);
    if (roll < 45) begin
      send_word(ACT_ALLOC, PAGE_W'($urandom), OFFSET_W'($urandom));
    end else if (roll < 80) begin
      slot = pick_used_slot();
      if (slot < 0 || model_size == 0) begin
        off = OFFSET_W'($urandom);
      end else begin
        byte_pos = longint'(slot) * model_size + $urandom_range(model_size - 1);
        off      = byte_pos[OFFSET_W-1:0];
      end
      send_word(ACT_FREE, PAGE_W'($urandom), off);
    end else begin
      if ($urandom_range(1)) begin
        off = OFFSET_W'($urandom);
      end else begin
        byte_pos = longint'(pool_limit()) * model_size;
        if ($urandom_range(1) && byte_pos > 0) byte_pos = byte_pos - 1;
        off = byte_pos[OFFSET_W-1:0];
      end
      send_word(ACT_FREE, PAGE_W'($urandom), off);
    end
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  // Write both registers back to back; only call with the block idle
  task automatic set_pool(input logic [COUNT_W-1:0] count, input logic [SIZE_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we      <= 1'b0;
    model_count = count;
    model_size  = size;
  endtask

  // --------------------------------------------------------------------------
  // Response side: check each word, then decide ready for the next edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pool_reply_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (replies_due.size() == 0) begin
          $error("response word with nothing predicted: status %0d slot %0d offset %0d",
                 rsp_ch.status, rsp_ch.slot_index, rsp_ch.byte_offset);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, rsp_ch.slot_index);
            errors++;
          end
          if (rsp_ch.byte_offset !== want.offset) begin
            $error("byte_offset: expected %0d, got %0d", want.offset, rsp_ch.byte_offset);
            errors++;
          end
        end
      end
      // A long hold asked for by a test takes priority over random bursts
      if (hold_served != hold_order) begin
        hold_served = hold_order;
        hold_left   = hold_span;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        gap_left = $urandom_range(10);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and the corner cases, one word at a time
  task automatic test_directed();
    idle_pct = 0;
    // Reset defaults: 4096 blocks of 64 bytes, empty bitmap
    send_word(ACT_ALLOC, 4'd0, '0);
    send_word(ACT_ALLOC, 4'd15, '1);
    send_word(ACT_ALLOC, 4'd1, '0);
    send_word(ACT_FREE, 4'd0, 28'd0);
    send_word(ACT_FREE, 4'd15, 28'd0);              // double free
    send_word(ACT_FREE, 4'd0, 28'd16453);           // unaligned, inside slot 257
    send_word(ACT_FREE, 4'd0, '1);                  // far past the pool
    send_word(ACT_ALLOC, 4'd5, 28'h5555555);
    settle();
    // No pages at all
    set_pool(13'd0, 16'd64);
    send_word(ACT_ALLOC, 4'd7, '0);
    send_word(ACT_FREE, 4'd0, 28'd0);
    settle();
    // Count beyond the pool clips; zero size zeroes offsets and rejects frees
    set_pool(13'd5000, 16'd0);
    send_word(ACT_ALLOC, 4'd3, 28'haaaaaaa);
    send_word(ACT_FREE, 4'd0, 28'd100);
    settle();
    // Single block, largest size; bits above the count stay but are ignored
    set_pool(13'd1, 16'd65535);
    send_word(ACT_ALLOC, 4'd9, '0);
    send_word(ACT_ALLOC, 4'd0, '0);                 // pool full
    send_word(ACT_FREE, 4'd0, 28'd65534);
    send_word(ACT_FREE, 4'd0, 28'd65535);
    settle();
    // Largest offsets the pool can reach
    set_pool(13'd4096, 16'd65535);
    send_word(ACT_ALLOC, 4'd15, '0);
    send_word(ACT_FREE, 4'd0, 28'd268431359);
    send_word(ACT_FREE, 4'd0, 28'd268431360);
    send_word(ACT_FREE, 4'd0, 28'd12345678);
    settle();
  endtask

  // Run a small one-page pool dry, then free some and refill
  task automatic test_pool_full();
    int slot;
    longint unsigned byte_pos;
    idle_pct = 20;
    set_pool(13'd40, 16'd8);
    repeat (48) send_word(ACT_ALLOC, PAGE_W'($urandom), OFFSET_W'($urandom));
    repeat (10) begin
      slot = pick_used_slot();
      byte_pos = longint'(slot < 0 ? 0 : slot) * model_size + $urandom_range(7);
      send_word(ACT_FREE, PAGE_W'($urandom), byte_pos[OFFSET_W-1:0]);
    end
    repeat (12) send_word(ACT_ALLOC, PAGE_W'($urandom), OFFSET_W'($urandom));
    settle();
  endtask

  // Hold the receiver off long enough for the queue to fill and stall req
  task automatic test_backpressure();
    idle_pct = 0;
    set_pool(13'd300, 16'd64);
    hold_span = 300;
    hold_order++;
    repeat (16) send_mixed_word();
    settle();
  endtask

  // Random phases, each with its own pool setting and idle rate
  task automatic test_random_mix();
    logic [COUNT_W-1:0] count;
    logic [SIZE_W-1:0]  size;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(7))
        0: count = 13'd1;
        1: count = 13'd32;
        2: count = 13'd33;
        3: count = 13'd257;
        4: count = 13'd4096;
        5: count = 13'($urandom_range(8191, 4097));
        default: count = 13'($urandom_range(4096, 1));
      endcase
      case ($urandom_range(7))
        0: size = 16'd1;
        1: size = 16'd65535;
        2: size = 16'd0;
        3: size = 16'd64;
        default: size = 16'($urandom_range(65535, 1));
      endcase
      case ($urandom_range(3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      set_pool(count, size);
      repeat (32) send_mixed_word();
      settle();
    end
  endtask

  // Closing stretch at full rate, no idling on either side
  task automatic test_steady_stream();
    idle_pct = 0;
    set_pool(13'($urandom_range(4096, 1)), 16'($urandom_range(65535, 1)));
    repeat (40) send_mixed_word();
    settle();
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_BLOCK_COUNT;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_ALLOC;
    req_ch.start_page  = '0;
    req_ch.free_offset = '0;
    rsp_ch.ready       = 1'b0;
    foreach (used_map[w]) used_map[w] = '0;
    model_count = BLOCK_COUNT_RST;
    model_size  = BLOCK_SIZE_RST;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_pool_full();
    test_backpressure();
    test_random_mix();
    test_steady_stream();

    settle();
    repeat (END_PAD) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("paged_bitmap_block_allocator_unit_tb: clean");
    end else begin
      $display("paged_bitmap_block_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule
